// ===== hw/rtl/psb_pkg.sv =====
`default_nettype none
package psb_pkg;

  // Host table geometry
  localparam int NUM_HOSTS  = 64;
  localparam int HOST_W     = $clog2(NUM_HOSTS);
  localparam int OUT_HOST_W = 6;
  localparam int PEN_W      = 5;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [PEN_W-1:0]  MAX_PENALTY_RST = PEN_W'(16);
  localparam logic [TIME_W-1:0] MIN_DELAY_RST   = TIME_W'(10 * 60);
  localparam logic [TIME_W-1:0] MAX_DELAY_RST   = TIME_W'(8 * 60 * 60);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENALTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 2'd2;

  // Request and outcome codes
  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [1:0] OC_REACHABLE = 2'd0;
  localparam logic [1:0] OC_HOST_DOWN = 2'd1;
  localparam logic [1:0] OC_NET_DOWN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL_RD,
    ST_SEL_EV,
    ST_RPT_RD,
    ST_RPT_EV,
    ST_DONE
  } psb_state_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic sel_eval;
    logic rpt_apply;
    logic out_load;
  } psb_cmd_t;

  typedef struct packed {
    logic walk_done;
  } psb_status_t;

  // Round-robin successor of a host index
  function automatic logic [HOST_W-1:0] next_host(input logic [HOST_W-1:0] h);
    if (h == HOST_W'(NUM_HOSTS - 1)) begin
      return '0;
    end else begin
      return h + HOST_W'(1);
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/probe_scheduler_with_backoff.sv =====
`default_nettype none
// Each item runs through the controller states: a report through read, apply and done, a select
//   through one read and evaluate pair per host the skip walk visits (1 to 30*NUM_HOSTS + 1 hosts).
// One item at a time: the next transfer is taken the cycle after the result is loaded. Each visit
//   is a read state and an evaluate state, set by the registered skip table read. A waiting
//   result holds the load and, with it, the next transfer.
// Reset (synchronous, rst_n low): tables read as zero, pointer at the last host,
//   backoff cleared, registers at their defaults; no clearing pass is needed.
module probe_scheduler_with_backoff (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_req_type,
  input  wire logic [1:0]                        in_outcome,
  input  wire logic [psb_pkg::TIME_W-1:0]        in_now_seconds,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [psb_pkg::OUT_HOST_W-1:0]         out_host_index,
  output logic                                   out_power_cycle,
  output logic                                   out_host_restored,
  output logic                                   out_host_dropped,
  output logic                                   out_network_restored,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [psb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import psb_pkg::*;

  psb_cmd_t    cmd;
  psb_status_t status;
  logic        cfg_we;

  // Register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  psb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  psb_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_req_type          (in_req_type),
    .in_outcome           (in_outcome),
    .in_now_seconds       (in_now_seconds),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_host_index       (out_host_index),
    .out_power_cycle      (out_power_cycle),
    .out_host_restored    (out_host_restored),
    .out_host_dropped     (out_host_dropped),
    .out_network_restored (out_network_restored)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/psb_ctrl.sv =====
`default_nettype none
module psb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_req_type,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire psb_pkg::psb_status_t status,
  output psb_pkg::psb_cmd_t        cmd
);
  import psb_pkg::*;

  psb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_req_type == REQ_REPORT) ? ST_RPT_RD : ST_SEL_RD;
        end
      end
      ST_SEL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEL_EV;
      end
      ST_SEL_EV: begin
        cmd.sel_eval = 1'b1;
        state_nxt    = status.walk_done ? ST_DONE : ST_SEL_RD;
      end
      ST_RPT_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_RPT_EV;
      end
      ST_RPT_EV: begin
        cmd.rpt_apply = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // load the output register once the previous result is gone
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/psb_dp.sv =====
`default_nettype none
module psb_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire psb_pkg::psb_cmd_t                 cmd,
  output psb_pkg::psb_status_t                   status,
  input  wire logic                              in_req_type,
  input  wire logic [1:0]                        in_outcome,
  input  wire logic [psb_pkg::TIME_W-1:0]        in_now_seconds,
  input  wire logic                              cfg_we,
  input  wire logic [psb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [psb_pkg::OUT_HOST_W-1:0]         out_host_index,
  output logic                                   out_power_cycle,
  output logic                                   out_host_restored,
  output logic                                   out_host_dropped,
  output logic                                   out_network_restored
);
  import psb_pkg::*;

  // Per-host tables; valid bits stand in for the cleared reset contents
  logic [PEN_W-1:0]     skip_mem [NUM_HOSTS];
  logic [PEN_W-1:0]     pen_mem  [NUM_HOSTS];
  logic [NUM_HOSTS-1:0] skip_vld_r, skip_vld_nxt;
  logic [NUM_HOSTS-1:0] pen_vld_r, pen_vld_nxt;
  logic [PEN_W-1:0]     skip_rd_r, pen_rd_r;
  logic                 skip_vrd_r, pen_vrd_r;

  logic [PEN_W-1:0]  max_pen_r, max_pen_nxt;
  logic [TIME_W-1:0] min_delay_r, min_delay_nxt;
  logic [TIME_W-1:0] max_delay_r, max_delay_nxt;

  logic [HOST_W-1:0] cur_host_r, cur_host_nxt;
  logic [HOST_W-1:0] walk_r, walk_nxt;
  logic [TIME_W-1:0] lct_r, lct_nxt;
  logic              lcv_r, lcv_nxt;
  logic [TIME_W-1:0] delay_r, delay_nxt;

  logic              req_r;
  logic [1:0]        oc_r;
  logic [TIME_W-1:0] now_r;

  logic pc_r, pc_nxt, rest_r, rest_nxt, drop_r, drop_nxt, net_r, net_nxt;

  logic [PEN_W-1:0]  skip_eff, pen_eff, pen_new;
  logic [PEN_W:0]    pen_dbl;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W:0]   delay_dbl;
  logic              backoff_hold;
  logic              skip_we, pen_we;
  logic [PEN_W-1:0]  skip_wdata, pen_wdata;

  // Table storage: one write and one registered read per table
  always_ff @(posedge clk) begin
    if (skip_we) begin
      skip_mem[walk_r] <= skip_wdata;
    end
    if (pen_we) begin
      pen_mem[walk_r] <= pen_wdata;
    end
    if (cmd.rd) begin
      skip_rd_r <= skip_mem[walk_r];
      pen_rd_r  <= pen_mem[walk_r];
    end
  end

  // Hold the captured request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      oc_r  <= in_outcome;
      now_r <= in_now_seconds;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_vld_r  <= '0;
      pen_vld_r   <= '0;
      skip_vrd_r  <= 1'b0;
      pen_vrd_r   <= 1'b0;
      max_pen_r   <= MAX_PENALTY_RST;
      min_delay_r <= MIN_DELAY_RST;
      max_delay_r <= MAX_DELAY_RST;
      cur_host_r  <= HOST_W'(NUM_HOSTS - 1);
      walk_r      <= '0;
      lct_r       <= '0;
      lcv_r       <= 1'b0;
      delay_r     <= '0;
      pc_r        <= 1'b0;
      rest_r      <= 1'b0;
      drop_r      <= 1'b0;
      net_r       <= 1'b0;
    end else begin
      skip_vld_r  <= skip_vld_nxt;
      pen_vld_r   <= pen_vld_nxt;
      if (cmd.rd) begin
        skip_vrd_r <= skip_vld_r[walk_r];
        pen_vrd_r  <= pen_vld_r[walk_r];
      end
      max_pen_r   <= max_pen_nxt;
      min_delay_r <= min_delay_nxt;
      max_delay_r <= max_delay_nxt;
      cur_host_r  <= cur_host_nxt;
      walk_r      <= walk_nxt;
      lct_r       <= lct_nxt;
      lcv_r       <= lcv_nxt;
      delay_r     <= delay_nxt;
      pc_r        <= pc_nxt;
      rest_r      <= rest_nxt;
      drop_r      <= drop_nxt;
      net_r       <= net_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_host_index       <= OUT_HOST_W'(cur_host_r);
      out_power_cycle      <= pc_r;
      out_host_restored    <= rest_r;
      out_host_dropped     <= drop_r;
      out_network_restored <= net_r;
    end
  end

  // Entries never written read as zero
  assign skip_eff = skip_vrd_r ? skip_rd_r : '0;
  assign pen_eff  = pen_vrd_r ? pen_rd_r : '0;
  assign status.walk_done = (skip_eff == '0) || (skip_eff == PEN_W'(1));

  // Penalty doubling with saturation
  assign pen_dbl = {pen_eff, 1'b0};
  always_comb begin
    if (pen_dbl > {1'b0, max_pen_r}) begin
      pen_new = max_pen_r;
    end else begin
      pen_new = pen_dbl[PEN_W-1:0];
    end
  end

  // Backoff interval check and doubling
  assign elapsed      = now_r - lct_r;
  assign backoff_hold = lcv_r && (elapsed < delay_r);
  assign delay_dbl    = {delay_r, 1'b0};

  // Next values of control state and table writes
  always_comb begin
    skip_vld_nxt  = skip_vld_r;
    pen_vld_nxt   = pen_vld_r;
    max_pen_nxt   = max_pen_r;
    min_delay_nxt = min_delay_r;
    max_delay_nxt = max_delay_r;
    cur_host_nxt  = cur_host_r;
    walk_nxt      = walk_r;
    lct_nxt       = lct_r;
    lcv_nxt       = lcv_r;
    delay_nxt     = delay_r;
    pc_nxt        = pc_r;
    rest_nxt      = rest_r;
    drop_nxt      = drop_r;
    net_nxt       = net_r;
    skip_we       = 1'b0;
    pen_we        = 1'b0;
    skip_wdata    = '0;
    pen_wdata     = '0;

    // Register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PENALTY: max_pen_nxt   = cfg_data[PEN_W-1:0];
        CFG_MIN_DELAY:   min_delay_nxt = cfg_data[TIME_W-1:0];
        CFG_MAX_DELAY:   max_delay_nxt = cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end

    // Start a walk at the successor, or point at the current host for a report
    if (cmd.capture) begin
      pc_nxt   = 1'b0;
      rest_nxt = 1'b0;
      drop_nxt = 1'b0;
      net_nxt  = 1'b0;
      walk_nxt = (in_req_type == REQ_REPORT) ? cur_host_r : next_host(cur_host_r);
    end

    // Visit one host: decrement its skip count, stop or advance
    if (cmd.sel_eval) begin
      if (skip_eff != '0) begin
        skip_we    = 1'b1;
        skip_wdata = skip_eff - PEN_W'(1);
        skip_vld_nxt[walk_r] = 1'b1;
      end
      if (status.walk_done) begin
        cur_host_nxt = walk_r;
      end else begin
        walk_nxt = next_host(walk_r);
      end
    end

    // Apply an outcome report to the current host
    if (cmd.rpt_apply && (req_r == REQ_REPORT)) begin
      case (oc_r)
        OC_REACHABLE: begin
          rest_nxt = (pen_eff != '0);
          skip_we  = 1'b1;
          pen_we   = 1'b1;
          skip_vld_nxt[walk_r] = 1'b1;
          pen_vld_nxt[walk_r]  = 1'b1;
          net_nxt   = lcv_r;
          lcv_nxt   = 1'b0;
          lct_nxt   = '0;
          delay_nxt = '0;
        end
        OC_HOST_DOWN: begin
          skip_we = 1'b1;
          pen_we  = 1'b1;
          skip_vld_nxt[walk_r] = 1'b1;
          pen_vld_nxt[walk_r]  = 1'b1;
          if (pen_eff != '0) begin
            skip_wdata = pen_new;
            pen_wdata  = pen_new;
          end else begin
            drop_nxt   = 1'b1;
            skip_wdata = PEN_W'(1);
            pen_wdata  = PEN_W'(1);
          end
          net_nxt   = lcv_r;
          lcv_nxt   = 1'b0;
          lct_nxt   = '0;
          delay_nxt = '0;
        end
        OC_NET_DOWN: begin
          if (!backoff_hold) begin
            pc_nxt  = 1'b1;
            lct_nxt = now_r;
            lcv_nxt = 1'b1;
            if (delay_r == '0) begin
              delay_nxt = min_delay_r;
            end else if (delay_dbl > {1'b0, max_delay_r}) begin
              delay_nxt = max_delay_r;
            end else begin
              delay_nxt = delay_dbl[TIME_W-1:0];
            end
          end
        end
        default: begin
          // unused outcome code: no change
        end
      endcase
    end
  end

endmodule
`default_nettype wire
